>>> rtl/bhmf_pkg.sv
// Shared types and constants for the block hash match finder.
// Field widths, command and status codes, FSM states and the
// controller/datapath command and status words. No dependencies.
package bhmf_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned TLEN_W = 13;
  localparam int unsigned SLEN_W = 13;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned MBLK_W = 9;
  localparam int unsigned MLEN_W = 13;
  localparam int unsigned MOFF_W = 13;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_SOURCE_LENGTH = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_SRC = 2'd0,
    CMD_WR_TGT = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_FIND   = 2'd3
  } bhmf_cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE     = 2'd0,
    STS_IGNORED  = 2'd1,
    STS_INVALID  = 2'd2,
    STS_NO_MATCH = 2'd3
  } bhmf_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_CHK,
    S_ADD_TAIL,
    S_ADD_LINK,
    S_F_HEAD,
    S_F_SCAN,
    S_F_CMP,
    S_F_NEXT,
    S_F_LEFT,
    S_F_RIGHT,
    S_DONE
  } bhmf_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_ADD_CHK,
    OP_ADD_TAIL,
    OP_ADD_LINK,
    OP_HEAD,
    OP_SCAN,
    OP_BLOCK,
    OP_NEXT,
    OP_LEFT,
    OP_RIGHT,
    OP_DONE
  } bhmf_op_e;

  typedef struct packed {
    bhmf_op_e op;
    logic     in_ready;
    logic     accept;
  } bhmf_ctl_t;

  typedef struct packed {
    logic      clr_last;
    bhmf_cmd_e in_cmd;
    logic      add_stop;
    logic      blk_valid;
    logic      cmp_done;
    logic      cmp_full;
    logic      probes_over;
    logic      hits_over;
    logic      out_free;
  } bhmf_sts_t;

endpackage

>>> rtl/bhmf_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on bhmf_pkg for field widths.
interface bhmf_in_if;
  logic                               valid;
  logic                               ready;
  logic [bhmf_pkg::CMD_W-1:0]         command;
  logic [bhmf_pkg::ADDR_W-1:0]        byte_address;
  logic [bhmf_pkg::BYTE_W-1:0]        byte_value;
  logic [bhmf_pkg::HASH_W-1:0]        hash_value;
  logic [bhmf_pkg::TLEN_W-1:0]        target_length;

  modport source (output valid, command, byte_address, byte_value, hash_value,
                  target_length, input ready);
  modport sink   (input valid, command, byte_address, byte_value, hash_value,
                  target_length, output ready);
endinterface

interface bhmf_out_if;
  logic                               valid;
  logic                               ready;
  logic [bhmf_pkg::STS_W-1:0]         status;
  logic signed [bhmf_pkg::MBLK_W-1:0] match_block;
  logic [bhmf_pkg::MLEN_W-1:0]        match_length;
  logic signed [bhmf_pkg::MOFF_W-1:0] match_target_offset;
  logic signed [bhmf_pkg::MOFF_W-1:0] match_source_offset;

  modport source (output valid, status, match_block, match_length,
                  match_target_offset, match_source_offset, input ready);
  modport sink   (input valid, status, match_block, match_length,
                  match_target_offset, match_source_offset, output ready);
endinterface

>>> rtl/block_hash_match_finder_unit.sv
// Block hash match finder for delta compression: byte stores, hash chains and
// best-match search. Depends on bhmf_pkg, bhmf_if, bhmf_ctrl, bhmf_dp.
//
// Use: request words arrive on in_i (valid/ready); each one gives exactly one
// result word on out_o. Commands write a source or target byte, add the next
// source block to its hash chain, or look up the longest match for a target
// offset. source_length is written over APB at byte address 0; pready is tied
// high and reads return the stored (saturated) length.
// Byte writes go through the done state to the result register; adds pass
// through the check state and, unless stopped there, the tail and link states.
// A lookup walks the hash chain, compares each block byte by byte and extends
// each full block hit left and right, all on one byte-wide read port of each
// store; one word is worked at a time. Reset, and every source_length write,
// starts a clearing pass over the chain tables, during which in_i.ready stays
// low.
// The result sits in an output register: the next request is taken while it
// waits, and a stalled receiver holds the block only once a second result is
// ready.
module block_hash_match_finder_unit #(
  parameter int unsigned SOURCE_BYTES = 4096,
  parameter int unsigned TARGET_BYTES = 4096,
  parameter int unsigned BLOCK_BYTES  = 16,
  parameter int unsigned MAX_PROBES   = 16,
  parameter int unsigned HEAD_ENTRIES = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bhmf_in_if.sink                     in_i,
  bhmf_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bhmf_pkg::APB_AW-1:0] paddr,
  input  logic [bhmf_pkg::APB_DW-1:0] pwdata,
  output logic [bhmf_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bhmf_pkg::*;

  bhmf_ctl_t         ctl;
  bhmf_sts_t         sts;
  logic              cfg_we;
  logic [SLEN_W-1:0] src_len;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SOURCE_LENGTH);
  assign prdata = (paddr[2] == REG_SOURCE_LENGTH) ? APB_DW'(src_len) : '0;

  assign in_i.ready = ctl.in_ready;

  bhmf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_we),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  bhmf_dp #(
    .SOURCE_BYTES (SOURCE_BYTES),
    .TARGET_BYTES (TARGET_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .MAX_PROBES   (MAX_PROBES),
    .HEAD_ENTRIES (HEAD_ENTRIES)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .ctl_i        (ctl),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata),
    .src_len_o    (src_len),
    .in_command_i (in_i.command),
    .in_addr_i    (in_i.byte_address),
    .in_byte_i    (in_i.byte_value),
    .in_hash_i    (in_i.hash_value),
    .in_tlen_i    (in_i.target_length),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_block_o  (out_o.match_block),
    .out_length_o (out_o.match_length),
    .out_toff_o   (out_o.match_target_offset),
    .out_soff_o   (out_o.match_source_offset)
  );

endmodule

>>> rtl/bhmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/bhmf_ctrl.sv
// Sequencer for the match finder: clear pass, add and find walks.
// Depends on bhmf_pkg; drives the datapath through bhmf_ctl_t.
module bhmf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                in_valid_i,
  input  bhmf_pkg::bhmf_sts_t sts_i,
  output bhmf_pkg::bhmf_ctl_t ctl_o
);
  import bhmf_pkg::*;

  bhmf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.in_cmd)
            CMD_ADD:  state_d = S_ADD_CHK;
            CMD_FIND: state_d = S_F_HEAD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_ADD_CHK: state_d = sts_i.add_stop ? S_DONE : S_ADD_TAIL;
      S_ADD_TAIL: state_d = S_ADD_LINK;
      S_ADD_LINK: state_d = S_DONE;
      S_F_HEAD: state_d = S_F_SCAN;
      S_F_SCAN: state_d = sts_i.blk_valid ? S_F_CMP : S_DONE;
      S_F_CMP: begin
        if (sts_i.cmp_done) begin
          if (sts_i.cmp_full) begin
            state_d = sts_i.hits_over ? S_DONE : S_F_LEFT;
          end else begin
            state_d = sts_i.probes_over ? S_DONE : S_F_NEXT;
          end
        end
      end
      S_F_NEXT: state_d = S_F_SCAN;
      S_F_LEFT: begin
        if (sts_i.cmp_done) state_d = S_F_RIGHT;
      end
      S_F_RIGHT: begin
        if (sts_i.cmp_done) state_d = S_F_NEXT;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    // a length write restarts the clear pass
    if (cfg_we_i) state_d = S_CLEAR;
  end

  always_comb begin
    ctl_o.in_ready = 1'b0;
    ctl_o.accept   = 1'b0;
    case (state_q)
      S_CLEAR:    ctl_o.op = OP_CLEAR;
      S_IDLE: begin
        ctl_o.op       = OP_ACCEPT;
        ctl_o.in_ready = 1'b1;
        ctl_o.accept   = in_valid_i;
      end
      S_ADD_CHK:  ctl_o.op = OP_ADD_CHK;
      S_ADD_TAIL: ctl_o.op = OP_ADD_TAIL;
      S_ADD_LINK: ctl_o.op = OP_ADD_LINK;
      S_F_HEAD:   ctl_o.op = OP_HEAD;
      S_F_SCAN:   ctl_o.op = OP_SCAN;
      S_F_CMP:    ctl_o.op = OP_BLOCK;
      S_F_NEXT:   ctl_o.op = OP_NEXT;
      S_F_LEFT:   ctl_o.op = OP_LEFT;
      S_F_RIGHT:  ctl_o.op = OP_RIGHT;
      S_DONE:     ctl_o.op = OP_DONE;
      default:    ctl_o.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/bhmf_dp.sv
// Datapath: byte stores, hash chain tables, byte compare engine,
// best-match registers and the result register. Depends on bhmf_pkg, bhmf_ram.
module bhmf_dp #(
  parameter int unsigned SOURCE_BYTES = 4096,
  parameter int unsigned TARGET_BYTES = 4096,
  parameter int unsigned BLOCK_BYTES  = 16,
  parameter int unsigned MAX_PROBES   = 16,
  parameter int unsigned HEAD_ENTRIES = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bhmf_pkg::bhmf_ctl_t                ctl_i,
  output bhmf_pkg::bhmf_sts_t                sts_o,
  input  logic                               cfg_we_i,
  input  logic [bhmf_pkg::APB_DW-1:0]        cfg_wdata_i,
  output logic [bhmf_pkg::SLEN_W-1:0]        src_len_o,
  input  logic [bhmf_pkg::CMD_W-1:0]         in_command_i,
  input  logic [bhmf_pkg::ADDR_W-1:0]        in_addr_i,
  input  logic [bhmf_pkg::BYTE_W-1:0]        in_byte_i,
  input  logic [bhmf_pkg::HASH_W-1:0]        in_hash_i,
  input  logic [bhmf_pkg::TLEN_W-1:0]        in_tlen_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bhmf_pkg::STS_W-1:0]         out_status_o,
  output logic signed [bhmf_pkg::MBLK_W-1:0] out_block_o,
  output logic [bhmf_pkg::MLEN_W-1:0]        out_length_o,
  output logic signed [bhmf_pkg::MOFF_W-1:0] out_toff_o,
  output logic signed [bhmf_pkg::MOFF_W-1:0] out_soff_o
);
  import bhmf_pkg::*;

  localparam int unsigned SA_W   = $clog2(SOURCE_BYTES);
  localparam int unsigned TA_W   = $clog2(TARGET_BYTES);
  localparam int unsigned BO_W   = $clog2(BLOCK_BYTES);
  localparam int unsigned CHAIN  = SOURCE_BYTES / BLOCK_BYTES;
  localparam int unsigned CH_W   = (CHAIN > 1) ? $clog2(CHAIN) : 1;
  localparam int unsigned BLK_W  = CH_W + 1;
  localparam int unsigned HI_W   = $clog2(HEAD_ENTRIES);
  localparam int unsigned CLR_N  = (HEAD_ENTRIES > CHAIN) ? HEAD_ENTRIES : CHAIN;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam int unsigned WMAX   = (SA_W > TA_W) ? SA_W : TA_W;
  localparam int unsigned CW     = ((WMAX > ADDR_W) ? WMAX : ADDR_W) + 3;
  localparam int unsigned MAX_HITS = (BLOCK_BYTES >= 32) ? 32 : 32 * (32 / BLOCK_BYTES);
  localparam int unsigned PW     = $clog2(MAX_PROBES + 1);
  localparam int unsigned HW     = $clog2(MAX_HITS + 1);

  function automatic logic [CW-1:0] smear(input logic [CW-1:0] v);
    logic [CW-1:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

  function automatic logic valid_b(input logic [BLK_W-1:0] b, input logic [CW-1:0] nb);
    return !b[BLK_W-1] && (CW'(b) < nb);
  endfunction

  // configuration and table state
  logic [CW-1:0]    slen_q, slen_d;
  logic [HI_W-1:0]  mask_q;
  logic [CLR_W-1:0] clr_q;
  logic [BLK_W-1:0] last_q;

  // current word
  bhmf_cmd_e        cmd_q;
  logic [CW-1:0]    addr_q, tlen_q;
  logic [HI_W-1:0]  hi_q;
  bhmf_status_e     status_q;

  // walk state
  logic [BLK_W-1:0] blk_q, first_q, last2_q;
  logic [PW-1:0]    n_q;
  logic [HW-1:0]    hits_q;
  logic [CW-1:0]    iss_q, cnt_q, maxl_q, maxr_q, left_q;
  logic             pv_q;
  logic [CW-1:0]    best_len_q;
  logic [BLK_W-1:0] best_blk_q;

  // RAM ports
  logic [BYTE_W-1:0] src_rd, tgt_rd;
  logic [SA_W-1:0]   src_ra;
  logic [TA_W-1:0]   tgt_ra;
  logic [BLK_W-1:0]  heads_rd, next_rd, tail_rd;
  logic              heads_we, next_we, tail_we;
  logic [HI_W-1:0]   heads_wa;
  logic [CH_W-1:0]   next_wa, next_ra, tail_wa;
  logic [BLK_W-1:0]  link_wd;

  logic              op_clr, in_cmp;
  logic [CW-1:0]     nblk, b_new_w, s_w, lim, cnt_nx, in_addr_w, in_tlen_w;
  logic [CW-1:0]     maxl_c, maxr_c, sr_c, tr_c, len_c;
  logic [BLK_W-1:0]  b_new;
  logic [HI_W-1:0]   hi_in;
  logic              eq, bad_off, reject, first_ok, add_new_head, link_ok, out_free;
  logic              find_none;

  assign op_clr    = (ctl_i.op == OP_CLEAR);
  assign nblk      = slen_q >> BO_W;
  assign b_new     = last_q + 1'b1;
  assign b_new_w   = CW'(b_new);
  assign s_w       = CW'(blk_q[CH_W-1:0]) << BO_W;
  assign hi_in     = in_hash_i[HI_W-1:0] & mask_q;
  assign in_addr_w = CW'(in_addr_i);
  assign in_tlen_w = CW'(in_tlen_i);
  assign src_len_o = SLEN_W'(slen_q);

  assign slen_d = (CW'(cfg_wdata_i[SLEN_W-1:0]) > CW'(SOURCE_BYTES)) ?
                  CW'(SOURCE_BYTES) : CW'(cfg_wdata_i[SLEN_W-1:0]);

  // add checks
  assign bad_off  = addr_q != (b_new_w << BO_W);
  assign reject   = (b_new_w >= nblk) || (next_rd != '1);
  assign first_ok = valid_b(heads_rd, nblk);
  assign add_new_head = (ctl_i.op == OP_ADD_CHK) && !bad_off && !reject && !first_ok;
  assign link_ok  = valid_b(last2_q, nblk) && (next_rd == '1);

  // byte compare engine: issue one address pair a cycle, compare the registered read bytes in the next cycle
  assign in_cmp = (ctl_i.op == OP_BLOCK) || (ctl_i.op == OP_LEFT) || (ctl_i.op == OP_RIGHT);
  assign eq     = (src_rd == tgt_rd);
  assign cnt_nx = cnt_q + CW'(pv_q && eq);

  always_comb begin
    case (ctl_i.op)
      OP_LEFT:  lim = maxl_q;
      OP_RIGHT: lim = maxr_q;
      default:  lim = CW'(BLOCK_BYTES);
    endcase
  end

  always_comb begin
    case (ctl_i.op)
      OP_LEFT: begin
        src_ra = SA_W'(s_w - CW'(1) - iss_q);
        tgt_ra = TA_W'(addr_q - CW'(1) - iss_q);
      end
      OP_RIGHT: begin
        src_ra = SA_W'(s_w + CW'(BLOCK_BYTES) + iss_q);
        tgt_ra = TA_W'(addr_q + CW'(BLOCK_BYTES) + iss_q);
      end
      default: begin
        src_ra = SA_W'(s_w + iss_q);
        tgt_ra = TA_W'(addr_q + iss_q);
      end
    endcase
  end

  // extension limits, taken when a block hits
  assign maxl_c = (s_w < addr_q) ? s_w : addr_q;
  assign sr_c   = slen_q - s_w - CW'(BLOCK_BYTES);
  assign tr_c   = tlen_q - addr_q - CW'(BLOCK_BYTES);
  assign maxr_c = (tlen_q >= addr_q + CW'(BLOCK_BYTES)) ? ((sr_c < tr_c) ? sr_c : tr_c) : '0;
  assign len_c  = CW'(BLOCK_BYTES) + left_q + cnt_nx;

  assign out_free  = !out_valid_o || out_ready_i;
  assign find_none = (cmd_q == CMD_FIND) && (best_len_q == '0);

  always_comb begin
    sts_o.clr_last    = (clr_q == CLR_W'(CLR_N - 1));
    sts_o.in_cmd      = bhmf_cmd_e'(in_command_i);
    sts_o.add_stop    = bad_off || reject || !first_ok;
    sts_o.blk_valid   = valid_b(blk_q, nblk);
    sts_o.cmp_done    = in_cmp && ((pv_q && !eq) || (cnt_nx == lim));
    sts_o.cmp_full    = (cnt_nx == lim);
    sts_o.probes_over = (n_q >= PW'(MAX_PROBES));
    sts_o.hits_over   = (hits_q >= HW'(MAX_HITS));
    sts_o.out_free    = out_free;
  end

  // memories
  bhmf_ram #(.WIDTH(BYTE_W), .DEPTH(SOURCE_BYTES)) u_src_ram (
    .clk_i,
    .we_i    (ctl_i.accept && (bhmf_cmd_e'(in_command_i) == CMD_WR_SRC)),
    .waddr_i (SA_W'(in_addr_w)),
    .wdata_i (in_byte_i),
    .raddr_i (src_ra),
    .rdata_o (src_rd)
  );

  bhmf_ram #(.WIDTH(BYTE_W), .DEPTH(TARGET_BYTES)) u_tgt_ram (
    .clk_i,
    .we_i    (ctl_i.accept && (bhmf_cmd_e'(in_command_i) == CMD_WR_TGT)),
    .waddr_i (TA_W'(in_addr_w)),
    .wdata_i (in_byte_i),
    .raddr_i (tgt_ra),
    .rdata_o (tgt_rd)
  );

  assign heads_we = op_clr || add_new_head;
  assign heads_wa = op_clr ? clr_q[HI_W-1:0] : hi_q;
  assign link_wd  = op_clr ? '1 : b_new;

  bhmf_ram #(.WIDTH(BLK_W), .DEPTH(HEAD_ENTRIES)) u_heads_ram (
    .clk_i,
    .we_i    (heads_we),
    .waddr_i (heads_wa),
    .wdata_i (link_wd),
    .raddr_i (hi_in),
    .rdata_o (heads_rd)
  );

  assign next_we = op_clr || ((ctl_i.op == OP_ADD_LINK) && link_ok);
  assign next_wa = op_clr ? clr_q[CH_W-1:0] : last2_q[CH_W-1:0];

  always_comb begin
    case (ctl_i.op)
      OP_ACCEPT:   next_ra = b_new[CH_W-1:0];
      OP_ADD_TAIL: next_ra = tail_rd[CH_W-1:0];
      default:     next_ra = blk_q[CH_W-1:0];
    endcase
  end

  bhmf_ram #(.WIDTH(BLK_W), .DEPTH(CHAIN)) u_next_ram (
    .clk_i,
    .we_i    (next_we),
    .waddr_i (next_wa),
    .wdata_i (link_wd),
    .raddr_i (next_ra),
    .rdata_o (next_rd)
  );

  assign tail_we = op_clr || add_new_head || ((ctl_i.op == OP_ADD_LINK) && link_ok);
  assign tail_wa = op_clr ? clr_q[CH_W-1:0] :
                   add_new_head ? b_new[CH_W-1:0] : first_q[CH_W-1:0];

  bhmf_ram #(.WIDTH(BLK_W), .DEPTH(CHAIN)) u_tail_ram (
    .clk_i,
    .we_i    (tail_we),
    .waddr_i (tail_wa),
    .wdata_i (link_wd),
    .raddr_i (heads_rd[CH_W-1:0]),
    .rdata_o (tail_rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slen_q      <= '0;
      mask_q      <= '0;
      clr_q       <= '0;
      last_q      <= '1;
      out_valid_o <= 1'b0;
      pv_q        <= 1'b0;
      iss_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        slen_q <= slen_d;
        mask_q <= HI_W'(smear(slen_d >> 2));
        clr_q  <= '0;
        last_q <= '1;
      end else begin
        if (op_clr) clr_q <= clr_q + 1'b1;
        if (add_new_head || ((ctl_i.op == OP_ADD_LINK) && link_ok)) last_q <= b_new;
      end

      if (in_cmp && !sts_o.cmp_done) begin
        iss_q <= iss_q + 1'b1;
        cnt_q <= cnt_nx;
        pv_q  <= 1'b1;
      end else begin
        iss_q <= '0;
        cnt_q <= '0;
        pv_q  <= 1'b0;
      end

      if ((ctl_i.op == OP_DONE) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_ACCEPT: begin
        if (ctl_i.accept) begin
          cmd_q      <= bhmf_cmd_e'(in_command_i);
          addr_q     <= in_addr_w;
          tlen_q     <= (in_tlen_w > CW'(TARGET_BYTES)) ? CW'(TARGET_BYTES) : in_tlen_w;
          hi_q       <= hi_in;
          status_q   <= STS_DONE;
          best_len_q <= '0;
          best_blk_q <= '1;
        end
      end
      OP_ADD_CHK: begin
        first_q <= heads_rd;
        if (bad_off) status_q <= STS_IGNORED;
        else if (reject) status_q <= STS_INVALID;
      end
      OP_ADD_TAIL: last2_q <= tail_rd;
      OP_ADD_LINK: status_q <= link_ok ? STS_DONE : STS_INVALID;
      OP_HEAD: begin
        blk_q  <= heads_rd;
        n_q    <= '0;
        hits_q <= '0;
      end
      OP_BLOCK: begin
        if (sts_o.cmp_done) begin
          if (sts_o.cmp_full) begin
            hits_q <= hits_q + 1'b1;
            maxl_q <= maxl_c;
            maxr_q <= maxr_c;
          end else begin
            n_q <= n_q + 1'b1;
          end
        end
      end
      OP_NEXT: blk_q <= next_rd;
      OP_LEFT: begin
        if (sts_o.cmp_done) left_q <= cnt_nx;
      end
      OP_RIGHT: begin
        if (sts_o.cmp_done) begin
          n_q <= '0;
          if (len_c > best_len_q) begin
            best_len_q <= len_c;
            best_blk_q <= blk_q;
          end
        end
      end
      OP_DONE: begin
        if (out_free) begin
          out_status_o <= find_none ? STS_NO_MATCH : status_q;
          out_block_o  <= MBLK_W'($signed(best_blk_q));
          out_length_o <= MLEN_W'(best_len_q);
          out_toff_o   <= (best_len_q == '0) ? '1 : MOFF_W'(addr_q);
          out_soff_o   <= (best_len_q == '0) ? '1 :
                          MOFF_W'(CW'(best_blk_q[CH_W-1:0]) << BO_W);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/bhmf_checker.sv
// Port-level checks for block_hash_match_finder_unit, bound to the top level.
// Depends on bhmf_pkg for widths and status codes.
module bhmf_checker #(
  parameter int unsigned BLOCK_BYTES = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [bhmf_pkg::STS_W-1:0]         status_i,
  input logic signed [bhmf_pkg::MBLK_W-1:0] block_i,
  input logic [bhmf_pkg::MLEN_W-1:0]        length_i,
  input logic                               cfg_we_i
);
  import bhmf_pkg::*;

  // result length and block hold while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(length_i) && $stable(block_i))
    else $error("result word changed while stalled");

  // a miss reports no block and no length
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STS_NO_MATCH) |-> (block_i == '1) && (length_i == '0))
    else $error("no-match result carries a block");

  // a found match spans at least one block
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (length_i != '0) |->
      (status_i == STS_DONE) && !block_i[MBLK_W-1] && (length_i >= MLEN_W'(BLOCK_BYTES)))
    else $error("match shorter than a block or with bad block");

  // length write starts the table clear, no request taken meanwhile
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("request accepted during table clear");

endmodule

bind block_hash_match_finder_unit bhmf_checker #(.BLOCK_BYTES(BLOCK_BYTES)) u_bhmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .block_i     (out_o.match_block),
  .length_i    (out_o.match_length),
  .cfg_we_i    (psel && penable && pwrite && !paddr[2])
);

>>> dv/block_hash_match_finder_unit_tb.sv
// Self-checking testbench for block_hash_match_finder_unit: fills source and target
// stores, links blocks into hash chains and checks every result word against a local model.
// Depends on bhmf_pkg, bhmf_if and the RTL of the block.
module block_hash_match_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bhmf_pkg::*;

  localparam int SRC_BYTES = 4096;
  localparam int TGT_BYTES = 4096;
  localparam int BLK = 16;
  localparam int PROBES = 16;
  localparam int HEADS = 2048;
  localparam int CHAINS = SRC_BYTES / BLK;
  localparam int HIT_LIMIT = 64;

  typedef struct packed {
    bhmf_cmd_e   cmd;
    logic [11:0] addr;
    logic [7:0]  val;
    logic [31:0] hash;
    logic [12:0] tlen;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [8:0]  blk;
    logic [12:0]        len;
    logic signed [12:0] toff;
    logic signed [12:0] soff;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  bhmf_in_if  req_ch ();
  bhmf_out_if rsp_ch ();

  block_hash_match_finder_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_ch.sink), .out_o(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  // model state
  logic [7:0] src_mem [SRC_BYTES];
  logic [7:0] tgt_mem [TGT_BYTES];
  int heads [HEADS];
  int nexts [CHAINS];
  int tails [CHAINS];
  int last_blk;
  int src_len;
  int mask;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int errors = 0;

  function automatic void set_source_length(int len);
    int t;
    t = 1;
    if (len > SRC_BYTES) len = SRC_BYTES;
    src_len = len;
    while (t < len / 4 + 1) t = t << 1;
    mask = t - 1;
    foreach (heads[i]) heads[i] = -1;
    foreach (nexts[i]) begin
      nexts[i] = -1;
      tails[i] = -1;
    end
    last_blk = -1;
  endfunction

  function automatic bit blk_ok(int b);
    return b >= 0 && b < src_len / BLK;
  endfunction

  function automatic int head_of(logic [31:0] h);
    return (h & mask) % HEADS;
  endfunction

  function automatic bit block_matches(int b, int toff);
    for (int k = 0; k < BLK; k++)
      if (src_mem[(b * BLK + k) % SRC_BYTES] != tgt_mem[(toff + k) % TGT_BYTES]) return 0;
    return 1;
  endfunction

  function automatic int walk_chain(int b, int toff);
    int n;
    n = 0;
    while (blk_ok(b) && !block_matches(b, toff)) begin
      n++;
      if (n > PROBES) return -1;
      b = nexts[b];
    end
    return blk_ok(b) ? b : -1;
  endfunction

  function automatic logic [1:0] link_block(logic [31:0] h);
    int b, hi, first, tl;
    b = last_blk + 1;
    if (b >= src_len / BLK) return STS_INVALID;
    if (nexts[b] != -1) return STS_INVALID;
    hi = head_of(h);
    first = heads[hi];
    if (!blk_ok(first)) begin
      heads[hi] = b;
      tails[b] = b;
    end else begin
      tl = tails[first];
      if (!blk_ok(tl) || nexts[tl] != -1) return STS_INVALID;
      nexts[tl] = b;
      tails[first] = b;
    end
    last_blk = b;
    return STS_DONE;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t o;
    int tl, a, b, hits, s, maxl, lft, rgt, maxr, sr, ln;
    o = '{status: STS_DONE, blk: -1, len: 0, toff: -1, soff: -1};
    tl = (r.tlen > TGT_BYTES) ? TGT_BYTES : r.tlen;
    a = r.addr;
    case (r.cmd)
      CMD_WR_SRC: begin
        src_mem[a] = r.val;
      end
      CMD_WR_TGT: begin
        tgt_mem[a] = r.val;
      end
      CMD_ADD: begin
        if (a != (last_blk + 1) * BLK) o.status = STS_IGNORED;
        else o.status = link_block(r.hash);
      end
      default: begin
        hits = 0;
        b = walk_chain(heads[head_of(r.hash)], a);
        while (b >= 0) begin
          s = b * BLK;
          maxl = s < a ? s : a;
          lft = 0;
          rgt = 0;
          maxr = 0;
          sr = src_len - s - BLK;
          hits++;
          if (hits > HIT_LIMIT) break;
          while (lft < maxl && src_mem[s - 1 - lft] == tgt_mem[a - 1 - lft]) lft++;
          if (tl >= a + BLK) maxr = sr < tl - a - BLK ? sr : tl - a - BLK;
          while (rgt < maxr && src_mem[(s + BLK + rgt) % SRC_BYTES] ==
                 tgt_mem[(a + BLK + rgt) % TGT_BYTES]) rgt++;
          ln = BLK + lft + rgt;
          if (ln > o.len) begin
            o.len = ln;
            o.blk = b;
            o.toff = a;
            o.soff = s;
          end
          b = walk_chain(nexts[b], a);
        end
        if (o.blk < 0) o.status = STS_NO_MATCH;
      end
    endcase
    return o;
  endfunction

  // driver
  bit drv_active = 0;
  int drv_gap = 0;
  req_t cur_req;
  int stall_left = 0;
  bit accepted_flag = 0;
  initial begin
    req_ch.valid = 1'b0;
    req_ch.command = '0;
    req_ch.byte_address = '0;
    req_ch.byte_value = '0;
    req_ch.hash_value = '0;
    req_ch.target_length = '0;
    rsp_ch.ready = 1'b0;
  end

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!drv_active || accepted_flag) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          req_ch.valid <= 1'b0;
          drv_active <= 0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.command <= cur_req.cmd;
          req_ch.byte_address <= cur_req.addr;
          req_ch.byte_value <= cur_req.val;
          req_ch.hash_value <= cur_req.hash;
          req_ch.target_length <= cur_req.tlen;
          drv_active <= 1;
          drv_gap <= rand_gap();
        end else begin
          req_ch.valid <= 1'b0;
          drv_active <= 0;
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                      (stall_left > 0 ? 1'b0 : 1'b1);
      if (stall_left > 0) stall_left <= stall_left - 1;
      else if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(10, 80);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t got, exp_r;
    accepted_flag <= rst_ni && req_ch.valid && req_ch.ready;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(predict_result(cur_req));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.status, rsp_ch.match_block, rsp_ch.match_length,
                rsp_ch.match_target_offset, rsp_ch.match_source_offset};
        if (expected_rsps.size() == 0) begin
          $error("result word with none expected");
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.blk !== exp_r.blk) begin
            $error("match_block exp %0d got %0d", exp_r.blk, got.blk); errors++;
          end
          if (got.len !== exp_r.len) begin
            $error("match_length exp %0d got %0d", exp_r.len, got.len); errors++;
          end
          if (got.toff !== exp_r.toff) begin
            $error("match_target_offset exp %0d got %0d", exp_r.toff, got.toff);
            errors++;
          end
          if (got.soff !== exp_r.soff) begin
            $error("match_source_offset exp %0d got %0d", exp_r.soff, got.soff);
            errors++;
          end
        end
      end
    end
  end

  task automatic apb_write(logic [12:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_SOURCE_LENGTH, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    set_source_length(value);
  endtask

  // queue plus model-side tracking of what was written, so lookups avoid unwritten bytes
  bit plan_src [SRC_BYTES];
  bit plan_tgt [TGT_BYTES];
  logic [7:0] plan_val [SRC_BYTES];
  int plan_len;
  int plan_nb;

  function automatic void q_req(bhmf_cmd_e c, int a, int v, logic [31:0] h, int tl);
    pending_reqs.push_back('{c, 12'(a), 8'(v), h, 13'(tl)});
    if (c == CMD_WR_SRC) plan_src[a % SRC_BYTES] = 1;
    if (c == CMD_WR_TGT) plan_tgt[a % TGT_BYTES] = 1;
  endfunction

  // a lookup is safe if every byte it may touch was written; only the first
  // plan_nb blocks sit in the chains, and rightward extension is bounded by both lengths
  function automatic bit find_safe(int a, int tl);
    int rmax, shi;
    if (plan_nb == 0) return 1;
    rmax = (tl >= a + BLK) ? tl - a - BLK : 0;
    if (rmax > plan_len - BLK) rmax = plan_len - BLK;
    shi = plan_nb * BLK + rmax;
    if (shi > plan_len) shi = plan_len;
    for (int i = 0; i < shi; i++) if (!plan_src[i]) return 0;
    for (int i = 0; i < a + BLK + rmax; i++) if (!plan_tgt[i % TGT_BYTES]) return 0;
    return 1;
  endfunction

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_reqs.size() > 0 || drv_active || expected_rsps.size() > 0)
           && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  // builds one phase: copy a source region into the target with edits, add blocks, look up
  task automatic run_phase(int len, int n_blk, int n_src, int n_tgt, int n_items,
                           bit extremes);
    int nb, a, tl, v;
    logic [31:0] hashes [CHAINS];
    apb_write(13'(len));
    plan_len = (len > SRC_BYTES) ? SRC_BYTES : len;
    nb = (plan_len / BLK < n_blk) ? plan_len / BLK : n_blk;
    plan_nb = 0;
    // source bytes from a tiny alphabet so matches and chains are common
    for (int i = 0; i < n_src; i++) begin
      v = extremes ? ((i % 3 == 0) ? 8'hFF : 8'h00) : $urandom_range(0, 3);
      plan_val[i] = 8'(v);
      q_req(CMD_WR_SRC, i, v, $urandom, $urandom_range(0, 8191));
    end
    // target mostly copies the source in place, with some moved or random bytes
    for (int i = 0; i < n_tgt; i++) begin
      a = ($urandom_range(0, 9) < 8) ? i : $urandom_range(0, n_src);
      v = (a < n_src) ? int'(plan_val[a]) : $urandom_range(0, 3);
      q_req(CMD_WR_TGT, i, v, $urandom, $urandom_range(0, 8191));
    end
    for (int b = 0; b < nb; b++) begin
      hashes[b] = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0)
        q_req(CMD_ADD, $urandom_range(0, 4095), 0, $urandom, 0);
      q_req(CMD_ADD, b * BLK, $urandom, hashes[b], $urandom_range(0, 8191));
    end
    plan_nb = nb;
    // one add past the last whole block
    if (nb == plan_len / BLK) q_req(CMD_ADD, nb * BLK, 0, $urandom, 0);
    for (int k = 0; k < n_items; k++) begin
      a = $urandom_range(0, n_tgt > BLK ? n_tgt - BLK : 0);
      case ($urandom_range(0, 2))
        0:       tl = $urandom_range(0, a + BLK);
        1:       tl = a + BLK + $urandom_range(0, 24);
        default: tl = 8191;
      endcase
      if (!find_safe(a, tl > TGT_BYTES ? TGT_BYTES : tl)) begin
        tl = a + BLK;
        if (!find_safe(a, tl)) continue;
      end
      q_req(CMD_FIND, a, $urandom, (nb > 0 && $urandom_range(0, 4) > 0) ?
            hashes[$urandom_range(0, nb - 1)] : $urandom, tl);
    end
    wait_idle();
  endtask

  initial begin
    set_source_length(0);
    plan_nb = 0;
    plan_len = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // write-only and corner items with zero length
    q_req(CMD_WR_SRC, 4095, 255, 32'hFFFF_FFFF, 8191);
    q_req(CMD_WR_TGT, 4095, 0, 0, 0);
    q_req(CMD_ADD, 0, 0, 0, 0);
    q_req(CMD_ADD, 16, 0, 0, 0);
    wait_idle();
    run_phase(8191, 3, 64, 64, 16, 1);
    run_phase(0, 0, 0, 0, 4, 0);
    run_phase(48, 3, 49, 56, 30, 0);
    run_phase(17, 1, 18, 24, 10, 0);
    run_phase(40, 2, 41, 48, 20, 0);
    if (errors == 0 && expected_rsps.size() == 0 && pending_reqs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end
endmodule
